// ===== sv/hesd_pkg.sv =====
// ----------------------------------------------------------------------------
// hesd_pkg
// Types, constants and helpers shared by the hex escape stream decoder.
// ----------------------------------------------------------------------------
package hesd_pkg;

    localparam int unsigned MaxOut = 4;   // most bytes one input word can release

    localparam logic [7:0] EscLead  = 8'h5F;   // '_'
    localparam logic [7:0] EscMark  = 8'h58;   // 'X'
    localparam logic [7:0] ChZero   = 8'h30;   // '0'
    localparam logic [7:0] ChNine   = 8'h39;   // '9'
    localparam logic [7:0] ChLowA   = 8'h61;   // 'a'
    localparam logic [7:0] ChLowF   = 8'h66;   // 'f'

    // input word
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_word;

    // escape match progress
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,   // nothing held
        PH_LEAD  = 2'd1,   // holds "_"
        PH_MARK  = 2'd2,   // holds "_X"
        PH_DIGIT = 2'd3    // holds "_X" and one hex digit
    } t_phase;

    // bytes released by one input word, oldest in slot 0
    typedef struct packed {
        logic [MaxOut-1:0][7:0] bytes;
        logic [2:0]             count;
        logic                   last;
    } t_bundle;

    // lowercase hex digit check; bit 4 is the valid flag
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [7:0] d;
        d = 8'd0;
        if (b >= ChZero && b <= ChNine) begin
            d = b - ChZero;
            return {1'b1, d[3:0]};
        end
        if (b >= ChLowA && b <= ChLowF) begin
            d = b - ChLowA + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

// ===== sv/hex_escape_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// hex_escape_stream_decoder
// Replaces each "_X" plus two lowercase hex digit escape with the byte it
// encodes; other bytes pass through, broken escapes are released as they came.
// ----------------------------------------------------------------------------
// Output: first output word in the cycle after the input word is accepted.
// Throughput: one input word per cycle while each releases at most one byte
//   and the output does not stall; a word that releases more bytes (up to 4)
//   stalls the input until the output register, which presents one byte at
//   a time, is handing out the last byte of the bundle; output stalls add to that.
// Reset: synchronous, active low; clears the held escape and empties the
//   output register.
// ----------------------------------------------------------------------------
module hex_escape_stream_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  hesd_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_stall,
    output hesd_pkg::t_out_word o_word
);
    import hesd_pkg::*;

    t_bundle bundle;
    logic    free;
    logic    accept;

    assign o_stall = !free;
    assign accept  = i_valid && free;

    // escape matcher
    hesd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_word   (i_word),
        .o_bundle (bundle)
    );

    // output register and byte sequencer
    hesd_serialize u_serialize (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_bundle (bundle),
        .o_free   (free),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_word   (o_word)
    );

    // checks
    a_bundle_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (bundle.count <= 3'd4))
        else $error("bundle holds more than four bytes");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_word.in_last) |=> o_valid)
        else $error("end of string released no byte");

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with nothing to send");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

// ===== sv/hesd_decode.sv =====
// ----------------------------------------------------------------------------
// hesd_decode
// Escape matcher: holds the partial escape and works out, for each input
// word, the bundle of bytes it releases.
// ----------------------------------------------------------------------------
module hesd_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  hesd_pkg::t_in_word i_word,
    output hesd_pkg::t_bundle o_bundle
);
    import hesd_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;

    t_phase     mid_phase;    // phase after this byte, before end-of-string flush
    logic       taken;
    logic       release_old;
    logic [4:0] hv_in;
    logic [4:0] hv_held;

    assign hv_in   = hex_value(i_word.in_byte);
    assign hv_held = hex_value(r_held);

    // next state
    always_comb begin
        mid_phase   = r_phase;
        n_held      = r_held;
        taken       = 1'b0;
        release_old = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
            end
            PH_LEAD: begin
                if (i_word.in_byte == EscMark) begin
                    mid_phase = PH_MARK;
                    taken     = 1'b1;
                end else begin
                    release_old = 1'b1;
                end
            end
            PH_MARK: begin
                if (hv_in[4]) begin
                    n_held    = i_word.in_byte;
                    mid_phase = PH_DIGIT;
                    taken     = 1'b1;
                end else begin
                    release_old = 1'b1;
                end
            end
            PH_DIGIT: begin
                if (hv_in[4]) begin
                    mid_phase = PH_IDLE;
                    taken     = 1'b1;
                end else begin
                    release_old = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (release_old) begin
            mid_phase = PH_IDLE;
        end
        if (!taken && i_word.in_byte == EscLead) begin
            mid_phase = PH_LEAD;
        end
        n_phase = i_word.in_last ? PH_IDLE : mid_phase;
    end

    // released bytes, in order
    always_comb begin
        o_bundle       = '0;
        o_bundle.last  = i_word.in_last;
        // broken escape: held bytes go out as they came
        if (release_old) begin
            if (r_phase != PH_IDLE) begin
                o_bundle.bytes[o_bundle.count[1:0]] = EscLead;
                o_bundle.count = o_bundle.count + 3'd1;
            end
            if (r_phase == PH_MARK || r_phase == PH_DIGIT) begin
                o_bundle.bytes[o_bundle.count[1:0]] = EscMark;
                o_bundle.count = o_bundle.count + 3'd1;
            end
            if (r_phase == PH_DIGIT) begin
                o_bundle.bytes[o_bundle.count[1:0]] = r_held;
                o_bundle.count = o_bundle.count + 3'd1;
            end
        end
        // completed escape
        if (taken && r_phase == PH_DIGIT) begin
            o_bundle.bytes[o_bundle.count[1:0]] = {hv_held[3:0], hv_in[3:0]};
            o_bundle.count = o_bundle.count + 3'd1;
        end
        // plain byte
        if (!taken && i_word.in_byte != EscLead) begin
            o_bundle.bytes[o_bundle.count[1:0]] = i_word.in_byte;
            o_bundle.count = o_bundle.count + 3'd1;
        end
        // end of string: flush what is still held
        if (i_word.in_last) begin
            if (mid_phase != PH_IDLE) begin
                o_bundle.bytes[o_bundle.count[1:0]] = EscLead;
                o_bundle.count = o_bundle.count + 3'd1;
            end
            if (mid_phase == PH_MARK || mid_phase == PH_DIGIT) begin
                o_bundle.bytes[o_bundle.count[1:0]] = EscMark;
                o_bundle.count = o_bundle.count + 3'd1;
            end
            if (mid_phase == PH_DIGIT) begin
                o_bundle.bytes[o_bundle.count[1:0]] = n_held;
                o_bundle.count = o_bundle.count + 3'd1;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 8'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

// ===== sv/hesd_serialize.sv =====
// ----------------------------------------------------------------------------
// hesd_serialize
// Result register: holds one bundle and hands its bytes out one word at a
// time; tells the input side when a new bundle may be loaded.
// ----------------------------------------------------------------------------
module hesd_serialize (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  hesd_pkg::t_bundle   i_bundle,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_stall,
    output hesd_pkg::t_out_word o_word
);
    import hesd_pkg::*;

    logic [MaxOut-1:0][7:0] r_bytes, n_bytes;
    logic [2:0]             r_cnt, n_cnt;
    logic                   r_last, n_last;
    logic                   take;

    assign o_valid         = (r_cnt != 3'd0);
    assign take            = o_valid && !i_stall;
    assign o_free          = (r_cnt == 3'd0) || (r_cnt == 3'd1 && !i_stall);
    assign o_word.out_byte = r_bytes[0];
    assign o_word.out_last = r_last && (r_cnt == 3'd1);

    // load a new bundle or shift out the front byte
    always_comb begin
        n_bytes = r_bytes;
        n_cnt   = r_cnt;
        n_last  = r_last;
        if (i_load) begin
            n_bytes = i_bundle.bytes;
            n_cnt   = i_bundle.count;
            n_last  = i_bundle.last;
        end else if (take) begin
            n_bytes = {8'd0, r_bytes[MaxOut-1:1]};
            n_cnt   = r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
        r_last  <= n_last;
    end

endmodule
